@@ rtl/acs_pkg.sv @@
package acs_pkg;

    localparam int CP_W          = 21;
    localparam int IDX_W         = 6;
    localparam int TABLE_ENTRIES = 51;   // must stay below NO_INDEX

    localparam logic [IDX_W-1:0] NO_INDEX = {IDX_W{1'b1}};

    localparam logic [CP_W-1:0] BASE_CODE = 21'h000622;
    localparam logic [CP_W-1:0] VOWEL_LO  = 21'h00064B;
    localparam logic [CP_W-1:0] VOWEL_HI  = 21'h000652;

    localparam logic [7:0] LAM_OFFSET = 8'd34;

    localparam logic [CP_W-1:0] CP_ALEF_MADDA       = 21'h000622;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_ABOVE = 21'h000623;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_BELOW = 21'h000625;
    localparam logic [CP_W-1:0] CP_ALEF             = 21'h000627;

    localparam logic [15:0] LIG_LA_MADDA       = 16'hFEF5;
    localparam logic [15:0] LIG_LA_HAMZA_ABOVE = 16'hFEF7;
    localparam logic [15:0] LIG_LA_HAMZA_BELOW = 16'hFEF9;
    localparam logic [15:0] LIG_LA_PLAIN       = 16'hFEFB;

    // Classified-request queue between front and back
    localparam int QUEUE_DEPTH = 2;      // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Back-end shaping window: letter, vowel, next letter
    localparam int BUF_DEPTH = 3;
    localparam int BUF_IDX_W = 2;

    typedef struct packed {
        logic [7:0]        base;       // offset of the base letter from BASE_CODE
        logic [15:0]       form_end;   // final form
        logic signed [7:0] beg;        // initial form, relative to final
        logic signed [7:0] mid;        // medial form, relative to final
        logic signed [7:0] iso;        // isolated form, relative to final
        logic              jprev;      // joins to the previous letter
        logic              jnext;      // joins to the next letter
    } acs_rom_t;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [IDX_W-1:0] idx;
        logic             vowel;
        logic             last;
    } acs_item_t;

    typedef struct packed {
        logic [BUF_IDX_W-1:0] count;
        logic                 fin_pending;
        logic                 prev_none;
    } acs_back_stat_t;

    function automatic acs_rom_t mk_entry(
        input logic [7:0]        base,
        input logic [15:0]       fend,
        input logic signed [7:0] beg,
        input logic signed [7:0] mid,
        input logic signed [7:0] iso,
        input logic              jprev,
        input logic              jnext
    );
        acs_rom_t e;
        e.base     = base;
        e.form_end = fend;
        e.beg      = beg;
        e.mid      = mid;
        e.iso      = iso;
        e.jprev    = jprev;
        e.jnext    = jnext;
        return e;
    endfunction

    function automatic acs_rom_t rom_entry(input logic [IDX_W-1:0] i);
        acs_rom_t e;
        case (i)
            6'd0:    e = mk_entry(8'd1,   16'hFE84, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd1:    e = mk_entry(8'd2,   16'hFE86, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd2:    e = mk_entry(8'd3,   16'hFE88, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd3:    e = mk_entry(8'd4,   16'hFE8A, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b0);
            6'd4:    e = mk_entry(8'd5,   16'hFE8E, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd5:    e = mk_entry(8'd6,   16'hFE90, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd6:    e = mk_entry(8'd92,  16'hFB57, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd7:    e = mk_entry(8'd8,   16'hFE96, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd8:    e = mk_entry(8'd9,   16'hFE9A, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd9:    e = mk_entry(8'd10,  16'hFE9E, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd10:   e = mk_entry(8'd100, 16'hFB7B, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd11:   e = mk_entry(8'd11,  16'hFEA2, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd12:   e = mk_entry(8'd12,  16'hFEA6, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd13:   e = mk_entry(8'd13,  16'hFEAA, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd14:   e = mk_entry(8'd14,  16'hFEAC, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd15:   e = mk_entry(8'd15,  16'hFEAE, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd16:   e = mk_entry(8'd16,  16'hFEB0, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd17:   e = mk_entry(8'd118, 16'hFB8B, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd18:   e = mk_entry(8'd17,  16'hFEB2, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd19:   e = mk_entry(8'd18,  16'hFEB6, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd20:   e = mk_entry(8'd19,  16'hFEBA, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd21:   e = mk_entry(8'd20,  16'hFEBE, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd22:   e = mk_entry(8'd21,  16'hFEC2, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd23:   e = mk_entry(8'd22,  16'hFEC6, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd24:   e = mk_entry(8'd23,  16'hFECA, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd25:   e = mk_entry(8'd24,  16'hFECE, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd26:   e = mk_entry(8'd30,  16'h0640, 8'sd0,  8'sd0, 8'sd0,  1'b1, 1'b1);
            6'd27:   e = mk_entry(8'd31,  16'hFED2, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd28:   e = mk_entry(8'd32,  16'hFED6, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd29:   e = mk_entry(8'd135, 16'hFB8F, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd30:   e = mk_entry(8'd33,  16'hFEDA, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd31:   e = mk_entry(8'd141, 16'hFB93, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd32:   e = mk_entry(8'd34,  16'hFEDE, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd33:   e = mk_entry(8'd35,  16'hFEE2, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd34:   e = mk_entry(8'd36,  16'hFEE6, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd35:   e = mk_entry(8'd38,  16'hFEEE, -8'sd1, 8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd36:   e = mk_entry(8'd37,  16'hFEEA, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd37:   e = mk_entry(8'd39,  16'hFEF0, 8'sd0,  8'sd0, -8'sd1, 1'b1, 1'b0);
            6'd38:   e = mk_entry(8'd40,  16'hFEF2, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd39:   e = mk_entry(8'd170, 16'hFBFD, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b1);
            6'd40:   e = mk_entry(8'd7,   16'hFE94, 8'sd1,  8'sd2, -8'sd1, 1'b1, 1'b0);
            6'd41:   e = mk_entry(8'd206, 16'h06F0, 8'sd1,  8'sd2, -8'sd1, 1'b0, 1'b0);
            6'd42:   e = mk_entry(8'd207, 16'h06F1, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd43:   e = mk_entry(8'd208, 16'h06F2, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd44:   e = mk_entry(8'd209, 16'h06F3, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd45:   e = mk_entry(8'd210, 16'h06F4, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd46:   e = mk_entry(8'd211, 16'h06F5, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd47:   e = mk_entry(8'd212, 16'h06F6, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd48:   e = mk_entry(8'd213, 16'h06F7, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd49:   e = mk_entry(8'd214, 16'h06F8, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            6'd50:   e = mk_entry(8'd215, 16'h06F9, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
            default: e = mk_entry(8'd0,   16'h0000, 8'sd0,  8'sd0, 8'sd0,  1'b0, 1'b0);
        endcase
        return e;
    endfunction

    function automatic logic [CP_W-1:0] form_code(
        input acs_rom_t          e,
        input logic signed [7:0] off
    );
        return CP_W'(e.form_end) + CP_W'(off);
    endfunction

    function automatic logic [CP_W-1:0] base_code(input acs_rom_t e);
        return CP_W'(e.base) + BASE_CODE;
    endfunction

    function automatic logic rom_match(input acs_rom_t e, input logic [CP_W-1:0] cp);
        return (e.form_end != 16'h0000) &&
               ((cp == base_code(e)) || (cp == CP_W'(e.form_end)) ||
                (cp == form_code(e, e.beg)) || (cp == form_code(e, e.mid)) ||
                (cp == form_code(e, e.iso)));
    endfunction

    function automatic logic is_vowel(input logic [CP_W-1:0] cp);
        return (cp >= VOWEL_LO) && (cp <= VOWEL_HI);
    endfunction

    // Lam-alef ligature code, zero when the pair does not form one
    function automatic logic [15:0] ligature_code(
        input acs_rom_t cur,
        input logic     cur_ok,
        input acs_rom_t nxt,
        input logic     nxt_ok
    );
        logic [CP_W-1:0] code;
        logic [15:0]     lig;
        code = base_code(nxt);
        lig  = 16'h0000;
        if (cur_ok && nxt_ok && (cur.base == LAM_OFFSET))
        begin
            priority if (code == CP_ALEF_MADDA)
                lig = LIG_LA_MADDA;
            else if (code == CP_ALEF_HAMZA_ABOVE)
                lig = LIG_LA_HAMZA_ABOVE;
            else if (code == CP_ALEF_HAMZA_BELOW)
                lig = LIG_LA_HAMZA_BELOW;
            else if (code == CP_ALEF)
                lig = LIG_LA_PLAIN;
            else
                lig = 16'h0000;
        end
        return lig;
    endfunction

endpackage

@@ rtl/arabic_contextual_shaper.sv @@
// Arabic contextual shaper. Feed a string one Unicode code point per request on the in_ channel
// and set is_last on its final code point; shaped presentation-form code points come back on
// the out_ channel, with last_out marking the final result of the string. Each letter takes its
// isolated, initial, medial or final form from its neighbors, vowel marks (U+064B..U+0652) pass
// through and do not break joining, lam followed by an alef becomes one lam-alef ligature
// (after lam, vowel, alef the vowel is dropped and the alef is shaped again on its own), and
// code points outside the 51-entry table pass through unchanged and break joining. A string
// yields at most as many results as requests, one request may release up to three results,
// and those leave one per cycle while out_stall is low. Throughput is one request per cycle
// while out_stall is low and no string end is draining: the front does the full table compare
// in the accepting cycle and writes a 2-entry queue, the back shapes one result per cycle from
// a 3-entry window and refills it in the same cycle. A letter is held until its right neighbor
// (one character, or two when a vowel follows) has arrived; a request behind an is_last waits
// until the window has drained. Each character passes the queue, window and result registers;
// results are registered, so out_stall has no combinational path to in_stall.
module arabic_contextual_shaper import acs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [CP_W-1:0] code_point,
    input  logic            is_last,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [CP_W-1:0] shaped_code_point,
    output logic            last_out
);

    acs_item_t      f_item;
    acs_item_t      q_head;
    logic           f_push;
    logic           q_full;
    logic           q_head_valid;
    logic           q_pop;
    acs_back_stat_t b_stat;

    // Front: accept the request and classify it against the letter table
    acs_front u_front (
        .in_valid   (in_valid),
        .code_point (code_point),
        .is_last    (is_last),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (f_push),
        .item       (f_item)
    );

    // Queue: decouple acceptance from shaping
    acs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .wr_item    (f_item),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head),
        .full       (q_full)
    );

    // Back: hold the joining window, pick forms and ligatures, drive the result register
    acs_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (q_head_valid),
        .head_item         (q_head),
        .pop               (q_pop),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .shaped_code_point (shaped_code_point),
        .last_out          (last_out),
        .stat              (b_stat)
    );

    // An accepted request is waiting in the queue on the next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> q_head_valid)
        else $error("accepted request missing from queue");

    // The back never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("pop from empty queue");

    // A new string only enters once the previous one has fully drained
    a_string_fence: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && b_stat.fin_pending) |=> (b_stat.count == BUF_IDX_W'(1)))
        else $error("request mixed into window of a finished string");

    // The last result of a string leaves no remembered letter behind
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_out) |-> b_stat.prev_none)
        else $error("previous letter kept across string end");

endmodule

@@ rtl/acs_front.sv @@
module acs_front import acs_pkg::*; (
    input  logic            in_valid,
    input  logic [CP_W-1:0] code_point,
    input  logic            is_last,
    input  logic            q_full,
    output logic            in_stall,
    output logic            push,
    output acs_item_t       item
);

    logic [TABLE_ENTRIES-1:0] hit;

    // Compare against every table entry in parallel
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit[i] = rom_match(rom_entry(IDX_W'(i)), code_point);
        end
    end

    // First match wins: lowest index has priority
    always_comb
    begin
        item.cp    = code_point;
        item.vowel = is_vowel(code_point);
        item.last  = is_last;
        item.idx   = NO_INDEX;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                item.idx = IDX_W'(i);
            end
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

@@ rtl/acs_queue.sv @@
module acs_queue import acs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  acs_item_t wr_item,
    input  logic      pop,
    output logic      head_valid,
    output acs_item_t head_item,
    output logic      full
);

    acs_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ rtl/acs_back.sv @@
module acs_back import acs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  acs_item_t       head_item,
    output logic            pop,
    input  logic            out_stall,
    output logic            out_valid,
    output logic [CP_W-1:0] shaped_code_point,
    output logic            last_out,
    output acs_back_stat_t  stat
);

    acs_item_t            buf_reg [BUF_DEPTH];
    acs_item_t            buf_next [BUF_DEPTH];
    logic [BUF_IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]     prev_reg, prev_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CP_W-1:0]      out_cp_reg, out_cp_next;
    logic                 out_last_reg, out_last_next;

    acs_rom_t             h_entry, n_entry, p_entry;
    logic [IDX_W-1:0]     nidx;
    logic                 fin, decidable, out_free, emit, final_res;
    logic                 jp, jn;
    logic [15:0]          lig;
    logic [CP_W-1:0]      res;
    logic [BUF_IDX_W-1:0] used, used_eff, remain;
    logic [IDX_W-1:0]     prev_upd;
    int                   src;

    always_comb
    begin
        // A string end sits only at the tail of the window
        fin = 1'b0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (BUF_IDX_W'(i) < count_reg)
            begin
                fin = fin | buf_reg[i].last;
            end
        end

        // Right neighbor, looking past one vowel
        nidx = NO_INDEX;
        if (count_reg >= BUF_IDX_W'(2))
        begin
            if (buf_reg[1].vowel)
            begin
                nidx = (count_reg == BUF_IDX_W'(3)) ? buf_reg[2].idx : NO_INDEX;
            end
            else
            begin
                nidx = buf_reg[1].idx;
            end
        end

        h_entry = rom_entry(buf_reg[0].idx);
        n_entry = rom_entry(nidx);
        p_entry = rom_entry(prev_reg);

        jp  = (prev_reg != NO_INDEX) && p_entry.jnext;
        jn  = (nidx != NO_INDEX) && n_entry.jprev;
        lig = ligature_code(h_entry, buf_reg[0].idx != NO_INDEX, n_entry, nidx != NO_INDEX);

        decidable = (count_reg != '0) &&
                    (buf_reg[0].vowel || (buf_reg[0].idx == NO_INDEX) || fin ||
                     ((count_reg >= BUF_IDX_W'(2)) &&
                      (!buf_reg[1].vowel || (count_reg == BUF_IDX_W'(3)))));

        used     = BUF_IDX_W'(1);
        prev_upd = prev_reg;
        if (buf_reg[0].vowel)
        begin
            res = buf_reg[0].cp;
        end
        else if (buf_reg[0].idx == NO_INDEX)
        begin
            res      = buf_reg[0].cp;
            prev_upd = NO_INDEX;
        end
        else if (lig != 16'h0000)
        begin
            res      = CP_W'(lig) + CP_W'(jp);
            prev_upd = NO_INDEX;
            used     = BUF_IDX_W'(2);
        end
        else
        begin
            prev_upd = buf_reg[0].idx;
            priority if (jp && jn)
                res = form_code(h_entry, h_entry.mid);
            else if (jn)
                res = form_code(h_entry, h_entry.beg);
            else if (jp)
                res = CP_W'(h_entry.form_end);
            else
                res = form_code(h_entry, h_entry.iso);
        end

        out_free  = !out_valid_reg || !out_stall;
        emit      = decidable && out_free;
        used_eff  = emit ? used : '0;
        remain    = count_reg - used_eff;
        final_res = emit && fin && (remain == '0);

        // Hold new requests behind a string end until the window drains
        pop = head_valid && (remain != BUF_IDX_W'(BUF_DEPTH)) && !(fin && (remain != '0));

        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            src         = i + int'(used_eff);
            buf_next[i] = buf_reg[i];
            if (src < BUF_DEPTH)
            begin
                buf_next[i] = buf_reg[BUF_IDX_W'(src)];
            end
        end
        if (pop)
        begin
            buf_next[remain] = head_item;
        end
        count_next = remain + BUF_IDX_W'(pop);

        prev_next = prev_reg;
        if (emit)
        begin
            prev_next = final_res ? NO_INDEX : prev_upd;
        end

        out_valid_next = out_valid_reg;
        out_cp_next    = out_cp_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            out_cp_next   = res;
            out_last_next = final_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prev_reg      <= NO_INDEX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
        out_cp_reg   <= out_cp_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign shaped_code_point = out_cp_reg;
    assign last_out          = out_last_reg;

    assign stat.count       = count_reg;
    assign stat.fin_pending = fin;
    assign stat.prev_none   = (prev_reg == NO_INDEX);

endmodule

@@ tb/shaping_checker.sv @@
`timescale 1ns / 1ps
module shaping_checker import acs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  logic [CP_W-1:0] code_point,
    input  logic            is_last,
    input  logic            out_valid,
    input  logic            out_stall,
    input  logic [CP_W-1:0] shaped_code_point,
    input  logic            last_out,
    output int              errors,
    output int              pending,
    output int              checked,
    output int              ligatures
);

    // Which presentation forms a letter has, relative to its final form
    typedef enum logic [1:0] {TWO_FORM, FOUR_FORM, ONE_FORM, YEH_FORM} form_set_t;
    typedef enum logic [1:0] {AT_ISOLATED, AT_INITIAL, AT_MEDIAL, AT_FINAL} place_t;

    typedef struct packed {
        logic [7:0]  ofs;    // base letter minus BASE_CODE
        logic [15:0] fin;    // final form
        form_set_t   forms;
        logic        jp;     // joins to the previous letter
        logic        jn;     // joins to the next letter
    } glyph_t;

    typedef struct packed {
        logic            last;
        logic [CP_W-1:0] cp;
    } shaped_t;

    logic [CP_W-1:0]  win [2];
    int               win_cnt = 0;
    logic [IDX_W-1:0] prev_idx = NO_INDEX;
    shaped_t          glyphs_due [$];
    shaped_t          want;
    int               err_count = 0;
    int               result_count = 0;
    int               ligature_count = 0;

    function automatic glyph_t row(input logic [7:0] ofs, input logic [15:0] fin,
                                   input form_set_t forms, input logic jp, input logic jn);
        glyph_t g;
        g.ofs   = ofs;
        g.fin   = fin;
        g.forms = forms;
        g.jp    = jp;
        g.jn    = jn;
        return g;
    endfunction

    function automatic glyph_t glyph(input logic [IDX_W-1:0] i);
        case (i)
            6'd0:    return row(8'd1,   16'hFE84, TWO_FORM,  1'b1, 1'b0);
            6'd1:    return row(8'd2,   16'hFE86, TWO_FORM,  1'b1, 1'b0);
            6'd2:    return row(8'd3,   16'hFE88, TWO_FORM,  1'b1, 1'b0);
            6'd3:    return row(8'd4,   16'hFE8A, FOUR_FORM, 1'b1, 1'b0);
            6'd4:    return row(8'd5,   16'hFE8E, TWO_FORM,  1'b1, 1'b0);
            6'd5:    return row(8'd6,   16'hFE90, FOUR_FORM, 1'b1, 1'b1);
            6'd6:    return row(8'd92,  16'hFB57, FOUR_FORM, 1'b1, 1'b1);
            6'd7:    return row(8'd8,   16'hFE96, FOUR_FORM, 1'b1, 1'b1);
            6'd8:    return row(8'd9,   16'hFE9A, FOUR_FORM, 1'b1, 1'b1);
            6'd9:    return row(8'd10,  16'hFE9E, FOUR_FORM, 1'b1, 1'b1);
            6'd10:   return row(8'd100, 16'hFB7B, FOUR_FORM, 1'b1, 1'b1);
            6'd11:   return row(8'd11,  16'hFEA2, FOUR_FORM, 1'b1, 1'b1);
            6'd12:   return row(8'd12,  16'hFEA6, FOUR_FORM, 1'b1, 1'b1);
            6'd13:   return row(8'd13,  16'hFEAA, TWO_FORM,  1'b1, 1'b0);
            6'd14:   return row(8'd14,  16'hFEAC, TWO_FORM,  1'b1, 1'b0);
            6'd15:   return row(8'd15,  16'hFEAE, TWO_FORM,  1'b1, 1'b0);
            6'd16:   return row(8'd16,  16'hFEB0, TWO_FORM,  1'b1, 1'b0);
            6'd17:   return row(8'd118, 16'hFB8B, TWO_FORM,  1'b1, 1'b0);
            6'd18:   return row(8'd17,  16'hFEB2, FOUR_FORM, 1'b1, 1'b1);
            6'd19:   return row(8'd18,  16'hFEB6, FOUR_FORM, 1'b1, 1'b1);
            6'd20:   return row(8'd19,  16'hFEBA, FOUR_FORM, 1'b1, 1'b1);
            6'd21:   return row(8'd20,  16'hFEBE, FOUR_FORM, 1'b1, 1'b1);
            6'd22:   return row(8'd21,  16'hFEC2, FOUR_FORM, 1'b1, 1'b1);
            6'd23:   return row(8'd22,  16'hFEC6, FOUR_FORM, 1'b1, 1'b1);
            6'd24:   return row(8'd23,  16'hFECA, FOUR_FORM, 1'b1, 1'b1);
            6'd25:   return row(8'd24,  16'hFECE, FOUR_FORM, 1'b1, 1'b1);
            6'd26:   return row(8'd30,  16'h0640, ONE_FORM,  1'b1, 1'b1);
            6'd27:   return row(8'd31,  16'hFED2, FOUR_FORM, 1'b1, 1'b1);
            6'd28:   return row(8'd32,  16'hFED6, FOUR_FORM, 1'b1, 1'b1);
            6'd29:   return row(8'd135, 16'hFB8F, FOUR_FORM, 1'b1, 1'b1);
            6'd30:   return row(8'd33,  16'hFEDA, FOUR_FORM, 1'b1, 1'b1);
            6'd31:   return row(8'd141, 16'hFB93, FOUR_FORM, 1'b1, 1'b1);
            6'd32:   return row(8'd34,  16'hFEDE, FOUR_FORM, 1'b1, 1'b1);
            6'd33:   return row(8'd35,  16'hFEE2, FOUR_FORM, 1'b1, 1'b1);
            6'd34:   return row(8'd36,  16'hFEE6, FOUR_FORM, 1'b1, 1'b1);
            6'd35:   return row(8'd38,  16'hFEEE, TWO_FORM,  1'b1, 1'b0);
            6'd36:   return row(8'd37,  16'hFEEA, FOUR_FORM, 1'b1, 1'b1);
            6'd37:   return row(8'd39,  16'hFEF0, YEH_FORM,  1'b1, 1'b0);
            6'd38:   return row(8'd40,  16'hFEF2, FOUR_FORM, 1'b1, 1'b1);
            6'd39:   return row(8'd170, 16'hFBFD, FOUR_FORM, 1'b1, 1'b1);
            6'd40:   return row(8'd7,   16'hFE94, FOUR_FORM, 1'b1, 1'b0);
            6'd41:   return row(8'd206, 16'h06F0, FOUR_FORM, 1'b0, 1'b0);
            // extended digits one to nine: single form, no joining
            default: return row(8'd165 + 8'(i), 16'h06C7 + 16'(i), ONE_FORM, 1'b0, 1'b0);
        endcase
    endfunction

    function automatic logic [CP_W-1:0] form_of(input glyph_t g, input place_t at);
        int delta;
        case (at)
            AT_FINAL:   delta = 0;
            AT_MEDIAL:  delta = (g.forms == FOUR_FORM) ? 2 : 0;
            AT_INITIAL: delta = (g.forms == FOUR_FORM) ? 1 : (g.forms == TWO_FORM) ? -1 : 0;
            default:    delta = (g.forms == ONE_FORM) ? 0 : -1;
        endcase
        return CP_W'(int'(g.fin) + delta);
    endfunction

    // First match wins, so a form shared with an earlier letter maps there
    function automatic logic [IDX_W-1:0] lookup(input logic [CP_W-1:0] cp);
        glyph_t g;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            g = glyph(IDX_W'(i));
            if (cp == CP_W'(g.ofs) + BASE_CODE || cp == form_of(g, AT_FINAL) ||
                cp == form_of(g, AT_INITIAL) || cp == form_of(g, AT_MEDIAL) ||
                cp == form_of(g, AT_ISOLATED))
                return IDX_W'(i);
        end
        return NO_INDEX;
    endfunction

    function automatic logic is_mark(input logic [CP_W-1:0] cp);
        return cp >= VOWEL_LO && cp <= VOWEL_HI;
    endfunction

    function automatic logic [CP_W-1:0] ligature_of(input logic [IDX_W-1:0] cur,
                                                    input logic [IDX_W-1:0] nxt);
        glyph_t          a;
        glyph_t          b;
        logic [CP_W-1:0] alef;
        if (cur == NO_INDEX || nxt == NO_INDEX)
            return '0;
        a = glyph(cur);
        b = glyph(nxt);
        if (a.ofs != LAM_OFFSET)
            return '0;
        alef = CP_W'(b.ofs) + BASE_CODE;
        case (alef)
            CP_ALEF_MADDA:       return CP_W'(LIG_LA_MADDA);
            CP_ALEF_HAMZA_ABOVE: return CP_W'(LIG_LA_HAMZA_ABOVE);
            CP_ALEF_HAMZA_BELOW: return CP_W'(LIG_LA_HAMZA_BELOW);
            CP_ALEF:             return CP_W'(LIG_LA_PLAIN);
            default:             return '0;
        endcase
    endfunction

    // Append one request to the window and queue every result it decides
    task automatic shape_request(input logic [CP_W-1:0] cp, input logic fin);
        logic [CP_W-1:0]  pend [3];
        logic [CP_W-1:0]  made [3];
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        logic [CP_W-1:0]  lig;
        glyph_t           g;
        logic             jp;
        logic             jn;
        logic             hold;
        int               n;
        int               k;
        int               used;
        n = win_cnt;
        for (int i = 0; i < n; i++)
            pend[i] = win[i];
        pend[n] = cp;
        n++;
        k = 0;
        hold = 1'b0;
        while (n > 0 && !hold)
        begin
            used = 1;
            if (is_mark(pend[0]))
                made[k] = pend[0];
            else
            begin
                cur = lookup(pend[0]);
                if (cur == NO_INDEX)
                begin
                    made[k] = pend[0];
                    prev_idx = NO_INDEX;
                end
                else
                begin
                    // hold a letter until its right neighbor is known
                    nxt = NO_INDEX;
                    if (n < 2)
                        hold = !fin;
                    else if (!is_mark(pend[1]))
                        nxt = lookup(pend[1]);
                    else if (n < 3)
                        hold = !fin;
                    else
                        nxt = lookup(pend[2]);
                    if (!hold)
                    begin
                        jp = 1'b0;
                        jn = 1'b0;
                        if (prev_idx != NO_INDEX)
                        begin
                            g = glyph(prev_idx);
                            jp = g.jn;
                        end
                        if (nxt != NO_INDEX)
                        begin
                            g = glyph(nxt);
                            jn = g.jp;
                        end
                        lig = ligature_of(cur, nxt);
                        g = glyph(cur);
                        if (lig != '0)
                        begin
                            made[k] = lig + CP_W'(jp);
                            prev_idx = NO_INDEX;
                            used = 2;
                            ligature_count++;
                        end
                        else
                        begin
                            if (jp && jn)
                                made[k] = form_of(g, AT_MEDIAL);
                            else if (jn)
                                made[k] = form_of(g, AT_INITIAL);
                            else if (jp)
                                made[k] = form_of(g, AT_FINAL);
                            else
                                made[k] = form_of(g, AT_ISOLATED);
                            prev_idx = cur;
                        end
                    end
                end
            end
            if (!hold)
            begin
                k++;
                for (int i = used; i < n; i++)
                    pend[i - used] = pend[i];
                n -= used;
            end
        end
        if (fin)
        begin
            prev_idx = NO_INDEX;
            n = 0;
        end
        for (int i = 0; i < n; i++)
            win[i] = pend[i];
        win_cnt = n;
        for (int i = 0; i < k; i++)
            glyphs_due.push_back('{last: fin && (i == k - 1), cp: made[i]});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cnt = 0;
            prev_idx = NO_INDEX;
            glyphs_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                shape_request(code_point, is_last);
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (glyphs_due.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, got %h last %b",
                             $time, shaped_code_point, last_out);
                end
                else
                begin
                    want = glyphs_due.pop_front();
                    if (shaped_code_point !== want.cp)
                    begin
                        err_count++;
                        $display("%0t: shaped_code_point: expected %h, got %h",
                                 $time, want.cp, shaped_code_point);
                    end
                    if (last_out !== want.last)
                    begin
                        err_count++;
                        $display("%0t: last_out: expected %b, got %b",
                                 $time, want.last, last_out);
                    end
                end
            end
        end
        errors    <= err_count;
        pending   <= glyphs_due.size();
        checked   <= result_count;
        ligatures <= ligature_count;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import acs_pkg::*;

    // Cycles with no request or result accepted before the run is called hung.
    localparam int STALL_LIMIT = 2000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [CP_W-1:0] code_point = '0;
    logic            is_last = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] shaped_code_point;
    logic            last_out;

    int errors;
    int pending;
    int checked;
    int ligatures;

    // Percentages of idle cycles on the request side and stall cycles on the result side
    int gap_pct = 0;
    int stall_pct = 0;

    int requests = 0;
    int strings = 0;
    int quiet = 0;

    always #4 clk = ~clk;

    arabic_contextual_shaper dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .code_point        (code_point),
        .is_last           (is_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .shaped_code_point (shaped_code_point),
        .last_out          (last_out)
    );

    shaping_checker shape_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .code_point        (code_point),
        .is_last           (is_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .shaped_code_point (shaped_code_point),
        .last_out          (last_out),
        .errors            (errors),
        .pending           (pending),
        .checked           (checked),
        .ligatures         (ligatures)
    );

    // Result side: stall at random, fresh draw every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (rst_n)
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Idle cycles go
    // in front of it; with no idle drawn, valid simply stays high from the last
    // request, so it is never dropped and raised within one edge.
    task automatic send_char(input logic [CP_W-1:0] cp, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        is_last    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests++;
        if (last)
            strings++;
    endtask

    // Drop valid and wait until every predicted result has come back. The
    // checker's count is registered, so let the next edge pass before trusting it.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One string of mostly well-formed text: letters, lam-alef pairs (with an
    // optional vowel between them), extended letters and digits, presentation
    // forms taken as input, vowels, and some noise over the full 21 bits.
    task automatic random_string;
        logic [CP_W-1:0] word [$];
        int              len;
        int              pick;
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                word.push_back(CP_W'($urandom_range(32'h0623, 32'h064A)));
            else if (pick < 55)
            begin
                word.push_back(21'h000644);
                if ($urandom_range(1) == 1)
                    word.push_back(VOWEL_LO + CP_W'($urandom_range(7)));
                case ($urandom_range(3))
                    0:       word.push_back(CP_ALEF_MADDA);
                    1:       word.push_back(CP_ALEF_HAMZA_ABOVE);
                    2:       word.push_back(CP_ALEF_HAMZA_BELOW);
                    default: word.push_back(CP_ALEF);
                endcase
            end
            else if (pick < 65)
            begin
                case ($urandom_range(11))
                    0:       word.push_back(21'h00067E);
                    1:       word.push_back(21'h000686);
                    2:       word.push_back(21'h000698);
                    3:       word.push_back(21'h0006A9);
                    4:       word.push_back(21'h0006AF);
                    5:       word.push_back(21'h0006CC);
                    6:       word.push_back(21'h000640);
                    7:       word.push_back(21'h000629);
                    default: word.push_back(21'h0006F0 + CP_W'($urandom_range(9)));
                endcase
            end
            else if (pick < 73)
                word.push_back(CP_W'($urandom_range(32'hFE70, 32'hFEFC)));
            else if (pick < 76)
                word.push_back(CP_W'($urandom_range(32'hFB50, 32'hFBFF)));
            else if (pick < 90)
                word.push_back(VOWEL_LO + CP_W'($urandom_range(7)));
            else
                word.push_back(CP_W'($urandom()));
        end
        foreach (word[j])
            send_char(word[j], j == word.size() - 1);
    endtask

    task automatic run_phase(input int gap, input int stall, input int amount);
        int stop_at;
        gap_pct   = gap;
        stall_pct = stall;
        stop_at   = requests + amount;
        while (requests < stop_at)
            random_string();
        drain();
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings, no idling on either side.
        // Lam then plain alef at the start of a string: bare ligature.
        send_char(21'h000644, 1'b0);  send_char(21'h000627, 1'b1);
        // Beh joins into lam, vowel, alef with hamza above: vowel dropped,
        // ligature joined to the left, alef shaped again on its own.
        send_char(21'h000628, 1'b0);  send_char(21'h000644, 1'b0);
        send_char(21'h00064E, 1'b0);  send_char(21'h000623, 1'b1);
        // Lam then alef with hamza below.
        send_char(21'h000644, 1'b0);  send_char(21'h000625, 1'b1);
        // Alef with madda is not in the table: lam stays alone, madda passes.
        send_char(21'h000644, 1'b0);  send_char(21'h000622, 1'b1);
        // Seen, tatweel, meem, then a string ending on a vowel.
        send_char(21'h000633, 1'b0);  send_char(21'h000640, 1'b0);
        send_char(21'h000645, 1'b0);  send_char(21'h000652, 1'b1);
        // The top code point breaks joining between two behs.
        send_char(21'h000628, 1'b0);  send_char(21'h1FFFFF, 1'b0);
        send_char(21'h000628, 1'b1);
        // Code point zero as a string of its own.
        send_char(21'h000000, 1'b1);
        // A digit that is also the initial form of the digit before it, then
        // the initial form of lam taken as lam, ligated with a plain alef.
        send_char(21'h0006F1, 1'b0);  send_char(21'h00FEDF, 1'b0);
        send_char(21'h000627, 1'b1);
        // A lone vowel, then a lone letter.
        send_char(21'h00064B, 1'b1);
        send_char(21'h000628, 1'b1);

        // Hold off until every result is back before the random part starts
        drain();

        // Random strings under four idle/stall mixes, draining between them
        run_phase(0, 0, 45);
        run_phase(87, 0, 45);
        run_phase(0, 87, 45);
        run_phase(30, 30, 45);

        // Keep the clock running to catch any result nobody asked for
        stall_pct = 0;
        repeat (16)
            @(posedge clk);

        $display("Sent %0d requests in %0d strings under four idle/stall mixes;",
                 requests, strings);
        $display("checked %0d results, %0d of them lam-alef ligatures.", checked, ligatures);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/acs_pkg.sv
rtl/acs_front.sv
rtl/acs_queue.sv
rtl/acs_back.sv
rtl/arabic_contextual_shaper.sv
tb/shaping_checker.sv
tb/testbench.sv
